@@ hdl/tcw_pkg.sv @@
// Package for the text console writer: field widths, item kinds, character codes,
// default geometry and the sequencer state type. No dependencies.
package tcw_pkg;

	localparam int KIND_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int INDEX_W     = 11;
	localparam int OUT_ROW_W   = 5;
	localparam int OUT_COL_W   = 7;
	localparam int CELL_W      = 16;

	localparam int DEF_ROWS    = 25;
	localparam int DEF_COLUMNS = 80;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_BLANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

@@ hdl/tcw_if.sv @@
// Channel interfaces of the text console writer: command, response and configuration.
// Depends on tcw_pkg for the field widths.
interface tcw_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::KIND_W-1:0]    kind;
	logic [tcw_pkg::CHAR_W-1:0]    char_code;
	logic [tcw_pkg::ATTR_W-1:0]    attribute;
	logic [tcw_pkg::INDEX_W-1:0]   cell_index;

	modport source (output valid, kind, char_code, attribute, cell_index, input ready);
	modport sink (input valid, kind, char_code, attribute, cell_index, output ready);
endinterface

interface tcw_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::OUT_ROW_W-1:0] cursor_row;
	logic [tcw_pkg::OUT_COL_W-1:0] cursor_column;
	logic [tcw_pkg::CELL_W-1:0]    cell_data;

	modport source (output valid, cursor_row, cursor_column, cell_data, input ready);
	modport sink (input valid, cursor_row, cursor_column, cell_data, output ready);
endinterface

interface tcw_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::ATTR_W-1:0]    data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hdl/text_console_writer.sv @@
// Text console writer top level: cursor sequencer, result register and cell store.
// Depends on tcw_pkg, the channel interfaces in tcw_if.sv and tcw_cell_store.
//
// Commands arrive on cmd, results leave on rsp and the blank attribute is written
// on cfg, which is always ready. Each command item gives exactly one result item
// holding the cursor after the command and, for a read, the addressed cell.
// A put item goes from acceptance straight to the done state and a read item
// passes through the read state first. A put that moves past the last row, and
// a clear item, run one address counter over the store with at most one cell
// written per cycle: a scroll copies each row up by one and blanks the last row,
// and a clear blanks every cell. Only one item is in work at a time; cmd.ready is
// low while it is handled. After reset the store is filled with spaces of
// attribute 7 in a pass over every cell, during which no command item is taken;
// configuration writes are still accepted. The result sits in an output register
// that is loaded from the done state. While the receiver stalls, one further item
// may be accepted and handled, and it then waits for the register to empty before
// the block takes another.
module text_console_writer #(
	parameter int ROWS    = tcw_pkg::DEF_ROWS,
	parameter int COLUMNS = tcw_pkg::DEF_COLUMNS
) (
	input  logic   clk,
	input  logic   arst_n,
	tcw_cmd_if.sink  cmd,
	tcw_rsp_if.source rsp,
	tcw_cfg_if.sink  cfg
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLUMNS);

	localparam logic [CNT_W-1:0]  CNT_LAST     = CNT_W'(CELL_COUNT - 1);
	localparam logic [CNT_W-1:0]  CNT_END      = CNT_W'(CELL_COUNT);
	localparam logic [CNT_W-1:0]  CNT_COLUMNS  = CNT_W'(COLUMNS);
	localparam logic [CNT_W-1:0]  CNT_LASTROW  = CNT_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ADDR_COLUMNS = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] ADDR_LASTROW = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);

	tcw_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]           cnt_q;
	logic [ROW_W-1:0]           row_q;
	logic [COL_W-1:0]           col_q;
	logic [ADDR_W-1:0]          row_base_q;
	logic [tcw_pkg::ATTR_W-1:0] blank_attr_q;
	logic                       rd_ok_q;
	logic [tcw_pkg::CELL_W-1:0] res_data_q;
	logic                       out_valid_q;
	logic [tcw_pkg::OUT_ROW_W-1:0] out_row_q;
	logic [tcw_pkg::OUT_COL_W-1:0] out_col_q;
	logic [tcw_pkg::CELL_W-1:0] out_data_q;

	logic                       cmd_fire;
	logic                       is_put;
	logic                       is_newline;
	logic                       row_advance;
	logic                       need_scroll;
	logic                       out_load;
	logic                       rd_in_range;

	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [tcw_pkg::CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]          mem_raddr;
	logic [tcw_pkg::CELL_W-1:0] mem_rdata;
	logic [tcw_pkg::CELL_W-1:0] blank_cell;

	assign cfg.ready   = 1'b1;
	assign cmd.ready   = (state_q == tcw_pkg::ST_IDLE);
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign is_put      = (cmd.kind == tcw_pkg::KIND_PUT);
	assign is_newline  = (cmd.char_code == tcw_pkg::NEWLINE_CHAR);
	assign row_advance = is_newline || (col_q == COL_LAST);
	assign need_scroll = row_advance && (row_q == ROW_LAST);
	assign rd_in_range = (32'(cmd.cell_index) < 32'(CELL_COUNT));
	assign blank_cell  = {blank_attr_q, tcw_pkg::SPACE_CHAR};
	assign out_load    = (state_q == tcw_pkg::ST_DONE) && (!out_valid_q || rsp.ready);

	assign rsp.valid         = out_valid_q;
	assign rsp.cursor_row    = out_row_q;
	assign rsp.cursor_column = out_col_q;
	assign rsp.cell_data     = out_data_q;

	tcw_cell_store #(
		.DEPTH (CELL_COUNT)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (cnt_q == CNT_LAST) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					priority if (is_put && need_scroll) begin
						state_d = tcw_pkg::ST_SCROLL;
					end else if (cmd.kind == tcw_pkg::KIND_CLEAR) begin
						state_d = tcw_pkg::ST_CLEAR;
					end else if (cmd.kind == tcw_pkg::KIND_READ) begin
						state_d = tcw_pkg::ST_READ;
					end else begin
						state_d = tcw_pkg::ST_DONE;
					end
				end
			end
			tcw_pkg::ST_READ: begin
				state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_SCROLL: begin
				if (cnt_q == CNT_END) begin
					state_d = tcw_pkg::ST_BLANK;
				end
			end
			tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
				if (cnt_q == CNT_LAST) begin
					state_d = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[ADDR_W-1:0];
		mem_wdata = blank_cell;
		mem_raddr = ADDR_W'(cmd.cell_index);
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CHAR};
			end
			tcw_pkg::ST_IDLE: begin
				mem_we    = cmd_fire && is_put && !is_newline;
				mem_waddr = row_base_q + ADDR_W'(col_q);
				mem_wdata = {cmd.attribute, cmd.char_code};
			end
			tcw_pkg::ST_SCROLL: begin
				mem_we    = (cnt_q != CNT_COLUMNS);
				mem_waddr = ADDR_W'(cnt_q - CNT_COLUMNS - 1'b1);
				mem_wdata = mem_rdata;
				mem_raddr = (cnt_q == CNT_END) ? '0 : cnt_q[ADDR_W-1:0];
			end
			tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			tcw_pkg::ST_READ, tcw_pkg::ST_DONE: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcw_pkg::ST_INIT;
			cnt_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			row_base_q   <= '0;
			blank_attr_q <= tcw_pkg::RESET_ATTR;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				blank_attr_q <= cfg.data;
			end
			unique case (state_q)
				tcw_pkg::ST_IDLE: begin
					if (cmd_fire && is_put) begin
						if (row_advance) begin
							col_q <= '0;
							if (need_scroll) begin
								cnt_q      <= CNT_COLUMNS;
								row_q      <= ROW_LAST;
								row_base_q <= ADDR_LASTROW;
							end else begin
								row_q      <= ROW_W'(row_q + 1'b1);
								row_base_q <= row_base_q + ADDR_COLUMNS;
							end
						end else begin
							col_q <= COL_W'(col_q + 1'b1);
						end
					end else if (cmd_fire && cmd.kind == tcw_pkg::KIND_CLEAR) begin
						cnt_q      <= '0;
						row_q      <= '0;
						col_q      <= '0;
						row_base_q <= '0;
					end
				end
				tcw_pkg::ST_SCROLL: begin
					cnt_q <= (cnt_q == CNT_END) ? CNT_LASTROW : CNT_W'(cnt_q + 1'b1);
				end
				tcw_pkg::ST_INIT, tcw_pkg::ST_BLANK, tcw_pkg::ST_CLEAR: begin
					cnt_q <= CNT_W'(cnt_q + 1'b1);
				end
				tcw_pkg::ST_READ, tcw_pkg::ST_DONE: begin
					cnt_q <= cnt_q;
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			rd_ok_q    <= rd_in_range;
			res_data_q <= '0;
		end else if (state_q == tcw_pkg::ST_READ) begin
			res_data_q <= rd_ok_q ? mem_rdata : '0;
		end
		if (out_load) begin
			out_row_q  <= tcw_pkg::OUT_ROW_W'(row_q);
			out_col_q  <= tcw_pkg::OUT_COL_W'(col_q);
			out_data_q <= res_data_q;
		end
	end

	a_row_base: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_base_q) == 32'(row_q) * COLUMNS)
		else $error("row base does not match the cursor row");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("a second item was taken while one was in work");

	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.kind == tcw_pkg::KIND_CLEAR |=> row_q == '0 && col_q == '0)
		else $error("clear did not home the cursor");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tcw_pkg::ST_SCROLL |-> row_q == ROW_LAST && col_q == '0)
		else $error("scroll runs with the cursor away from the start of the last row");

endmodule

@@ hdl/tcw_cell_store.sv @@
// Screen cell store: one write port and one read port with registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_cell_store #(
	parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [tcw_pkg::CELL_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [tcw_pkg::CELL_W-1:0]  rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ sim/tb_text_console_writer.sv @@
// Self-checking testbench for text_console_writer: drives command items, writes the blank
// attribute and checks every result against a cycle-free model of the console held here.
// Depends on tcw_pkg, the channel interfaces in tcw_if.sv and the text_console_writer RTL.
module tb_text_console_writer;

	typedef logic [tcw_pkg::KIND_W-1:0]  kind_t;
	typedef logic [tcw_pkg::CHAR_W-1:0]  char_t;
	typedef logic [tcw_pkg::ATTR_W-1:0]  attr_t;
	typedef logic [tcw_pkg::INDEX_W-1:0] index_t;

	localparam int ROWS           = tcw_pkg::DEF_ROWS;
	localparam int COLUMNS        = tcw_pkg::DEF_COLUMNS;
	localparam int CELLS          = ROWS * COLUMNS;
	localparam int ITEM_TARGET    = 1300;
	localparam int WATCHDOG_LIMIT = 5 * (CELLS + 1) + 1000;
	localparam int REPORT_LIMIT   = 10;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 20;

	localparam kind_t KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [tcw_pkg::OUT_ROW_W-1:0] row;
		logic [tcw_pkg::OUT_COL_W-1:0] col;
		logic [tcw_pkg::CELL_W-1:0]    data;
	} console_result_t;

	logic clk;
	logic arst_n;

	tcw_cmd_if cmd_ch ();
	tcw_rsp_if rsp_ch ();
	tcw_cfg_if cfg_ch ();

	text_console_writer #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic [tcw_pkg::CELL_W-1:0] shadow_screen [CELLS];
	int                         cursor_row_now;
	int                         cursor_col_now;
	attr_t                      blank_attr;

	console_result_t pending_results [$];

	int  mismatches;
	int  items_sent;
	int  kind_seen [4];
	int  scroll_count;
	int  last_row_wraps;
	int  cfg_writes;
	int  hold_left;
	int  idle_cycles;
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void start_next_line();
		if (cursor_row_now >= ROWS - 1) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				shadow_screen[i] = shadow_screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				shadow_screen[i] = {blank_attr, tcw_pkg::SPACE_CHAR};
			cursor_row_now = ROWS - 1;
			scroll_count++;
		end else begin
			cursor_row_now++;
		end
		cursor_col_now = 0;
	endfunction

	function automatic console_result_t console_apply(input kind_t kind,
			input char_t ch, input attr_t attr, input index_t idx);
		console_result_t res;
		res.data = '0;
		case (kind)
			tcw_pkg::KIND_PUT: begin
				if (ch == tcw_pkg::NEWLINE_CHAR) begin
					start_next_line();
				end else begin
					shadow_screen[cursor_row_now * COLUMNS + cursor_col_now] = {attr, ch};
					cursor_col_now++;
					if (cursor_col_now >= COLUMNS) begin
						if (cursor_row_now == ROWS - 1)
							last_row_wraps++;
						start_next_line();
					end
				end
			end
			tcw_pkg::KIND_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					shadow_screen[i] = {blank_attr, tcw_pkg::SPACE_CHAR};
				cursor_row_now = 0;
				cursor_col_now = 0;
			end
			tcw_pkg::KIND_READ: begin
				if (idx < CELLS)
					res.data = shadow_screen[idx];
			end
			default: begin
			end
		endcase
		res.row = cursor_row_now[tcw_pkg::OUT_ROW_W-1:0];
		res.col = cursor_col_now[tcw_pkg::OUT_COL_W-1:0];
		return res;
	endfunction

	function automatic char_t text_char();
		char_t c;
		do
			c = char_t'($urandom);
		while (c == tcw_pkg::NEWLINE_CHAR);
		return c;
	endfunction

	task automatic send_cmd(input kind_t kind, input char_t ch,
			input attr_t attr, input index_t idx);
		if (!calm && $urandom_range(99) < 8) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(2)) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.kind       <= kind;
		cmd_ch.char_code  <= ch;
		cmd_ch.attribute  <= attr;
		cmd_ch.cell_index <= idx;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		pending_results.push_back(console_apply(kind, ch, attr, idx));
		kind_seen[kind]++;
		items_sent++;
	endtask

	task automatic put_char(input char_t ch);
		send_cmd(tcw_pkg::KIND_PUT, ch, attr_t'($urandom), index_t'($urandom));
	endtask

	task automatic read_cell(input int idx);
		send_cmd(tcw_pkg::KIND_READ, char_t'($urandom), attr_t'($urandom), index_t'(idx));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_blank_attr(input attr_t value);
		wait_drained();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		blank_attr = value;
		cfg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic test_power_up();
		read_cell(0);
		read_cell(CELLS - 1);
		read_cell(CELLS);
		read_cell((1 << tcw_pkg::INDEX_W) - 1);
		send_cmd(KIND_UNUSED, '1, '1, '1);
		write_blank_attr(8'h00);
	endtask

	task automatic test_directed();
		send_cmd(tcw_pkg::KIND_PUT, 8'h41, 8'hFF, '0);
		send_cmd(tcw_pkg::KIND_PUT, 8'h00, 8'h00, '1);
		send_cmd(tcw_pkg::KIND_PUT, 8'hFF, 8'h80, 11'h2AA);
		for (int i = 0; i < 4; i++)
			send_cmd(tcw_pkg::KIND_READ, 8'hFF, 8'hFF, index_t'(i));
		send_cmd(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CHAR, 8'hFF, '1);
		read_cell(COLUMNS);
		send_cmd(tcw_pkg::KIND_CLEAR, 8'hFF, 8'hFF, '1);
		read_cell(0);
		read_cell(CELLS - 1);
		send_cmd(KIND_UNUSED, '0, '0, '0);
		write_blank_attr(8'hFF);
		send_cmd(tcw_pkg::KIND_CLEAR, '0, '0, '0);
		read_cell(0);
		read_cell(1024);
	endtask

	// Lines of random text until the cursor reaches the last row, then a full line that
	// wraps there, a short line ended by a newline and a second wrapping line.
	task automatic test_fill_and_scroll();
		int len;
		int tail_lines;
		tail_lines = 0;
		while (tail_lines < 3) begin
			if (cursor_row_now == ROWS - 1)
				tail_lines++;
			if (tail_lines == 1 || tail_lines == 3
					|| (tail_lines != 2 && $urandom_range(99) < 15))
				len = COLUMNS;
			else
				len = $urandom_range(0, 10);
			for (int i = 0; i < len; i++)
				put_char(text_char());
			if (len < COLUMNS)
				put_char(tcw_pkg::NEWLINE_CHAR);
			repeat ($urandom_range(1, 3))
				read_cell((cursor_row_now > 0 ? cursor_row_now - 1 : 0) * COLUMNS
					+ $urandom_range(0, 2 * COLUMNS - 1));
		end
	endtask

	task automatic test_backpressure();
		calm = 1'b1;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 30; i++) begin
			if (i % 3 == 2)
				read_cell(cursor_row_now * COLUMNS + $urandom_range(0, COLUMNS - 1));
			else
				put_char(text_char());
		end
		wait_drained();
		calm = 1'b0;
	endtask

	task automatic test_blank_attribute();
		attr_t settings [4];
		settings = '{8'h00, 8'hFF, attr_t'($urandom), tcw_pkg::RESET_ATTR};
		foreach (settings[s]) begin
			write_blank_attr(settings[s]);
			send_cmd(tcw_pkg::KIND_CLEAR, char_t'($urandom), attr_t'($urandom),
				index_t'($urandom));
			read_cell(0);
			put_char(text_char());
			for (int i = 0; i < ROWS; i++)
				put_char(tcw_pkg::NEWLINE_CHAR);
			read_cell(CELLS - COLUMNS - 1);
			read_cell(CELLS - 1);
		end
	endtask

	task automatic test_random();
		int pick;
		int len;
		int burst;
		burst = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = (burst >= 15 && burst < 35);
			pick = $urandom_range(99);
			if (pick < 45) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(70, 100) : $urandom_range(30);
				for (int i = 0; i < len; i++)
					put_char(($urandom_range(99) < 3) ? char_t'($urandom) : text_char());
				if ($urandom_range(99) < 60)
					put_char(tcw_pkg::NEWLINE_CHAR);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 6)) begin
					len = $urandom_range(99);
					if (len < 70)
						read_cell((cursor_row_now > 0 ? cursor_row_now - 1 : 0) * COLUMNS
							+ $urandom_range(0, 2 * COLUMNS - 1));
					else if (len < 90)
						read_cell($urandom_range(0, CELLS - 1));
					else
						read_cell($urandom_range(CELLS, (1 << tcw_pkg::INDEX_W) - 1));
				end
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 3))
					put_char(tcw_pkg::NEWLINE_CHAR);
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 3))
					send_cmd(KIND_UNUSED, char_t'($urandom), attr_t'($urandom),
						index_t'($urandom));
			end else if (pick < 95) begin
				send_cmd(tcw_pkg::KIND_CLEAR, char_t'($urandom), attr_t'($urandom),
					index_t'($urandom));
			end else begin
				case ($urandom_range(3))
					0:       write_blank_attr(8'h00);
					1:       write_blank_attr(8'hFF);
					default: write_blank_attr(attr_t'($urandom));
				endcase
			end
			burst++;
		end
		calm = 1'b0;
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (!calm && $urandom_range(99) < 8) begin
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		console_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Unexpected result: row %0d column %0d cell %h",
						rsp_ch.cursor_row, rsp_ch.cursor_column, rsp_ch.cell_data);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.cursor_row !== want.row || rsp_ch.cursor_column !== want.col
						|| rsp_ch.cell_data !== want.data) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("Expected row %0d col %0d cell %h, got %0d %0d %h",
							want.row, want.col, want.data,
							rsp_ch.cursor_row, rsp_ch.cursor_column, rsp_ch.cell_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout after %0d cycles without an item", idle_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.kind      = tcw_pkg::KIND_PUT;
		cmd_ch.char_code = '0;
		cmd_ch.attribute = '0;
		cmd_ch.cell_index = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.data      = '0;
		hold_left        = 0;
		idle_cycles      = 0;
		calm             = 1'b0;
		for (int i = 0; i < CELLS; i++)
			shadow_screen[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CHAR};
		cursor_row_now = 0;
		cursor_col_now = 0;
		blank_attr     = tcw_pkg::RESET_ATTR;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_power_up();
		test_directed();
		test_fill_and_scroll();
		test_backpressure();
		test_blank_attribute();
		test_random();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d items: %0d puts, %0d clears, %0d reads, %0d of the unused kind.",
			items_sent, kind_seen[tcw_pkg::KIND_PUT], kind_seen[tcw_pkg::KIND_CLEAR],
			kind_seen[tcw_pkg::KIND_READ], kind_seen[KIND_UNUSED]);
		$display("There were %0d scrolls, %0d wraps on the last row and %0d attribute writes.",
			scroll_count, last_row_wraps, cfg_writes);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
